/* sv/mdd_pkg.sv */
// Package for the multiplexed digit display driver: types, constants and the segment decoder.
package mdd_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 2;
    localparam int DIGIT_W    = 4;
    localparam int FRAME_W    = 12;
    localparam int SEG_W      = 7;
    localparam int SEL_W      = 4;
    localparam int TDIV_W     = 12;
    localparam int FIL_W      = 16;
    localparam int BRIGHT_W   = 8;
    localparam int PWM_W      = 8;
    localparam int TIMER_W    = 20;
    localparam int SPIN_CNT_W = 3;
    localparam int DIGIT_SLOTS = 4;

    // Config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Parameter defaults
    localparam int DEF_NUM_DIGITS = 4;
    localparam int DEF_PWM_PERIOD = 16;

    // Register reset values
    localparam logic [TDIV_W-1:0]   TDIV_RESET   = 12'd100;
    localparam logic [FIL_W-1:0]    FIL_RESET    = 16'd500;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'd16;

    // Digit select pattern per digit (frame bits 11:8)
    localparam logic [SEL_W-1:0] SELECT_BITS [DIGIT_SLOTS] = '{
        4'b0100, 4'b1000, 4'b0010, 4'b0001
    };

    // Spinning number start values per digit
    localparam logic [DIGIT_W-1:0] SPIN_START [DIGIT_SLOTS] = '{
        4'd4, 4'd2, 4'd6, 4'd9
    };

    // Spin count reload: digit i gets SPIN_LOAD - i
    localparam int SPIN_LOAD = 5;
    localparam logic [DIGIT_W-1:0] LAST_DECIMAL = 4'd9;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 2'd0,
        CMD_SET_DIGIT = 2'd1,
        CMD_SET_ANIM  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_DIV = 2'd0,
        REG_FIL_DIV  = 2'd1,
        REG_BRIGHT   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] digit_index;
        logic [DIGIT_W-1:0] digit_value;
        logic               animate;
    } in_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_word;
        logic               filament_level;
    } out_item_t;

    typedef struct packed {
        logic [TDIV_W-1:0]   tick_divider;
        logic [FIL_W-1:0]    filament_divider;
        logic [BRIGHT_W-1:0] brightness;
    } cfg_t;

    // Segments a..g as frame bits 7:1; values above nine stay dark
    function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] value);
        logic [SEG_W-1:0] seg;
        case (value)
            4'd0:    seg = 7'h7E;
            4'd1:    seg = 7'h30;
            4'd2:    seg = 7'h6D;
            4'd3:    seg = 7'h79;
            4'd4:    seg = 7'h33;
            4'd5:    seg = 7'h5B;
            4'd6:    seg = 7'h5F;
            4'd7:    seg = 7'h70;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h7B;
            default: seg = '0;
        endcase
        return seg;
    endfunction

endpackage

/* sv/mdd_cfg_regs.sv */
// Configuration register file: tick divider, filament divider, brightness.
module mdd_cfg_regs
    import mdd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (cfg_idx_t'(wr_index))
                REG_TICK_DIV: cfg_next.tick_divider     = wr_data[TDIV_W-1:0];
                REG_FIL_DIV:  cfg_next.filament_divider = wr_data[FIL_W-1:0];
                REG_BRIGHT:   cfg_next.brightness       = wr_data[BRIGHT_W-1:0];
                default:      cfg_next = cfg_reg;  // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_divider     <= TDIV_RESET;
            cfg_reg.filament_divider <= FIL_RESET;
            cfg_reg.brightness       <= BRIGHT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/mdd_core.sv */
// Display state and frame builder: counters, digit store, spin animation, frame word.
module mdd_core
    import mdd_pkg::*;
#(
    parameter int NUM_DIGITS = DEF_NUM_DIGITS,
    parameter int PWM_PERIOD = DEF_PWM_PERIOD
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      item_en,
    input  in_item_t  item,
    output out_item_t result
);

    localparam int DIG_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [DIG_W:0]     DIGIT_LIMIT = (DIG_W+1)'(NUM_DIGITS);
    localparam logic [PWM_W-1:0]   PWM_LIMIT   = PWM_W'(PWM_PERIOD);

    // State
    logic [DIGIT_W-1:0]    digit_store_reg [NUM_DIGITS];
    logic [DIGIT_W-1:0]    digit_store_next [NUM_DIGITS];
    logic [SPIN_CNT_W-1:0] spin_count_reg [NUM_DIGITS];
    logic [SPIN_CNT_W-1:0] spin_count_next [NUM_DIGITS];
    logic [DIGIT_W-1:0]    spin_number_reg [NUM_DIGITS];
    logic [DIGIT_W-1:0]    spin_number_next [NUM_DIGITS];
    logic                  animate_reg, animate_next;
    logic [TIMER_W-1:0]    spin_timer_reg, spin_timer_next;
    logic [DIG_W-1:0]      active_reg, active_next;
    logic [PWM_W-1:0]      pwm_reg, pwm_next;
    logic [TIMER_W-1:0]    dot_timer_reg, dot_timer_next;
    logic                  dot_phase_reg, dot_phase_next;
    logic [DIG_W-1:0]      dot_pos_reg, dot_pos_next;
    logic [FIL_W-1:0]      fil_timer_reg, fil_timer_next;
    logic                  fil_phase_reg, fil_phase_next;

    // Values after a tick
    logic [FIL_W:0]        fil_inc;
    logic                  fil_hit;
    logic [FIL_W-1:0]      t_fil_timer;
    logic                  t_fil_phase;
    logic [PWM_W-1:0]      pwm_inc;
    logic                  pwm_hit;
    logic [PWM_W-1:0]      t_pwm;
    logic [DIG_W:0]        active_inc;
    logic [DIG_W-1:0]      t_active;
    logic [TIMER_W-1:0]    dot_inc;
    logic                  dot_hit;
    logic [TIMER_W-1:0]    t_dot_timer;
    logic                  t_dot_phase;
    logic [DIG_W:0]        dot_pos_inc;
    logic [DIG_W-1:0]      t_dot_pos;
    logic [TIMER_W-1:0]    spin_inc;
    logic                  spin_hit;
    logic [TIMER_W-1:0]    t_spin_timer;
    logic [SPIN_CNT_W-1:0] t_spin_count [NUM_DIGITS];
    logic [DIGIT_W-1:0]    t_spin_number [NUM_DIGITS];

    // Frame
    logic [DIGIT_W-1:0]    shown;
    logic [SEL_W-1:0]      sel;
    logic                  dot_bit;
    logic                  blank;

    // Counters advanced by a tick
    always_comb begin
        fil_inc     = {1'b0, fil_timer_reg} + 1'b1;
        fil_hit     = fil_inc >= {1'b0, cfg.filament_divider};
        t_fil_timer = fil_hit ? '0 : fil_inc[FIL_W-1:0];
        t_fil_phase = fil_phase_reg ^ fil_hit;

        pwm_inc    = pwm_reg + 1'b1;
        pwm_hit    = pwm_inc >= PWM_LIMIT;
        t_pwm      = pwm_hit ? '0 : pwm_inc;
        active_inc = {1'b0, active_reg} + 1'b1;
        t_active   = active_reg;
        if (pwm_hit) begin
            t_active = (active_inc >= DIGIT_LIMIT) ? '0 : active_inc[DIG_W-1:0];
        end

        dot_inc     = dot_timer_reg + 1'b1;
        dot_hit     = dot_inc >= {cfg.tick_divider, 8'h00};
        t_dot_timer = dot_hit ? '0 : dot_inc;
        t_dot_phase = dot_phase_reg ^ dot_hit;
        dot_pos_inc = {1'b0, dot_pos_reg} + 1'b1;
        t_dot_pos   = dot_pos_reg;
        // position moves on the rising half of the blink
        if (dot_hit && t_dot_phase) begin
            t_dot_pos = (dot_pos_inc >= DIGIT_LIMIT) ? '0 : dot_pos_inc[DIG_W-1:0];
        end

        spin_inc     = spin_timer_reg + 1'b1;
        spin_hit     = spin_inc >= {1'b0, cfg.tick_divider, 7'h00};
        t_spin_timer = spin_hit ? '0 : spin_inc;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            t_spin_count[i]  = spin_count_reg[i];
            t_spin_number[i] = spin_number_reg[i];
            if (spin_hit) begin
                if (spin_count_reg[i] != '0 && animate_reg
                        && digit_store_reg[i] == spin_number_reg[i]) begin
                    t_spin_count[i] = spin_count_reg[i] - 1'b1;
                end
                t_spin_number[i] = (spin_number_reg[i] >= LAST_DECIMAL) ? '0 :
                                   spin_number_reg[i] + 1'b1;
            end
        end
    end

    // Frame from post-tick state
    always_comb begin
        shown = '0;
        sel   = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (t_active == DIG_W'(i)) begin
                shown = (t_spin_count[i] != '0) ? t_spin_number[i] : digit_store_reg[i];
                sel   = SELECT_BITS[i];
            end
        end
        dot_bit = (t_active == t_dot_pos) ? t_dot_phase : 1'b0;
        blank   = t_pwm >= cfg.brightness;

        result.frame_word     = blank ? '0 : {sel, seg_decode(shown), dot_bit};
        result.filament_level = t_fil_phase;
    end

    // Next state
    always_comb begin
        digit_store_next = digit_store_reg;
        spin_count_next  = spin_count_reg;
        spin_number_next = spin_number_reg;
        animate_next     = animate_reg;
        spin_timer_next  = spin_timer_reg;
        active_next      = active_reg;
        pwm_next         = pwm_reg;
        dot_timer_next   = dot_timer_reg;
        dot_phase_next   = dot_phase_reg;
        dot_pos_next     = dot_pos_reg;
        fil_timer_next   = fil_timer_reg;
        fil_phase_next   = fil_phase_reg;
        if (item_en) begin
            case (cmd_t'(item.cmd))
                CMD_TICK: begin
                    fil_timer_next   = t_fil_timer;
                    fil_phase_next   = t_fil_phase;
                    pwm_next         = t_pwm;
                    active_next      = t_active;
                    dot_timer_next   = t_dot_timer;
                    dot_phase_next   = t_dot_phase;
                    dot_pos_next     = t_dot_pos;
                    spin_timer_next  = t_spin_timer;
                    spin_count_next  = t_spin_count;
                    spin_number_next = t_spin_number;
                end
                CMD_SET_DIGIT: begin
                    // indexes past the last digit match nothing
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        if (item.digit_index == INDEX_W'(i)) begin
                            digit_store_next[i] = item.digit_value;
                        end
                    end
                end
                CMD_SET_ANIM: begin
                    animate_next = item.animate;
                    if (!item.animate) begin
                        for (int i = 0; i < NUM_DIGITS; i++) begin
                            spin_count_next[i] = SPIN_CNT_W'(SPIN_LOAD - i);
                        end
                    end
                end
                default: ;  // unused code, no effect
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                digit_store_reg[i] <= '0;
                spin_count_reg[i]  <= '0;
                spin_number_reg[i] <= SPIN_START[i];
            end
            animate_reg    <= 1'b0;
            spin_timer_reg <= '0;
            active_reg     <= '0;
            pwm_reg        <= '0;
            dot_timer_reg  <= '0;
            dot_phase_reg  <= 1'b0;
            dot_pos_reg    <= '0;
            fil_timer_reg  <= '0;
            fil_phase_reg  <= 1'b0;
        end else begin
            digit_store_reg <= digit_store_next;
            spin_count_reg  <= spin_count_next;
            spin_number_reg <= spin_number_next;
            animate_reg     <= animate_next;
            spin_timer_reg  <= spin_timer_next;
            active_reg      <= active_next;
            pwm_reg         <= pwm_next;
            dot_timer_reg   <= dot_timer_next;
            dot_phase_reg   <= dot_phase_next;
            dot_pos_reg     <= dot_pos_next;
            fil_timer_reg   <= fil_timer_next;
            fil_phase_reg   <= fil_phase_next;
        end
    end

`ifndef SYNTH
    // lit digit stays in range
    a_active_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, active_reg} < DIGIT_LIMIT)
        else $error("active digit out of range");

    // PWM counter stays below its period
    a_pwm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pwm_reg < PWM_LIMIT)
        else $error("pwm counter out of range");

    // a non-tick transfer leaves the counters alone
    a_no_tick_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        item_en && item.cmd != CMD_TICK |=> $stable(pwm_reg) && $stable(fil_timer_reg))
        else $error("counters moved on a non-tick transfer");
`endif

endmodule

/* sv/mux_digit_display_driver_unit.sv */
// Top level of the multiplexed four-digit seven-segment display driver.
//
// Usage:
//   s_ channel: one command item per transfer (tick, set digit, set animation).
//   m_ channel: one frame per tick item (frame word plus filament level);
//               set-digit, set-animation and the unused command code give none.
//   cfg channel: register writes (0 tick divider, 1 filament divider,
//               2 brightness); always ready, write only while the block is idle.
// Path: a tick item is captured in the input register, then its frame is
//   loaded into the output register when the item advances, so m_valid
//   rises once the tick has passed through both registers.
// Throughput: one item per cycle unless a tick waits on m_ready, set by the
//   single pass of counter updates and segment decode between the registers.
// Stall: while a frame waits on m_ready, the input register still takes
//   non-tick items and passes them on; a tick waits in the input register,
//   and s_ready drops once it is full and blocked.
// Reset (aresetn low, synchronous): both channels empty, all counters and
//   the digit store cleared, spin numbers at their start values, registers
//   back to 100, 500 and 16.
module mux_digit_display_driver_unit
    import mdd_pkg::*;
#(
    parameter int NUM_DIGITS = DEF_NUM_DIGITS,
    parameter int PWM_PERIOD = DEF_PWM_PERIOD
)
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    out_item_t core_result;
    logic      in_is_tick;
    logic      advance;

    assign cfg_ready = 1'b1;

    mdd_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // A tick needs room in the output register; other commands never do.
    assign in_is_tick = in_data_reg.cmd == CMD_TICK;
    assign advance    = in_valid_reg && (!in_is_tick || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    mdd_core #(
        .NUM_DIGITS (NUM_DIGITS),
        .PWM_PERIOD (PWM_PERIOD)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item_en (advance),
        .item    (in_data_reg),
        .result  (core_result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_is_tick) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_is_tick) begin
            out_data_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTH
    // a frame only shows up after a tick moved through the core
    a_frame_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(advance && in_is_tick))
        else $error("frame without a tick");

    // a held item is never dropped
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input item lost");

    // a lit frame selects exactly one digit
    a_select_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_word != '0 |-> $onehot(m_data.frame_word[11:8]))
        else $error("digit select not one-hot");

    // non-tick items do not touch the result channel
    a_no_frame_non_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_is_tick && !(m_valid && m_ready) |=> m_valid == $past(m_valid))
        else $error("result channel changed on a non-tick item");
`endif

endmodule
